// ----- src/siphash_2_4_stream_macros.svh -----
// Assertion macros used by the SipHash-2-4 round engine.
`ifndef SIPHASH_2_4_STREAM_MACROS_SVH
`define SIPHASH_2_4_STREAM_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SIP24_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("sip24 same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SIP24_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sip24 next-cycle check failed");

`endif

// ----- src/sip24_pkg.sv -----
// Package with the SipHash-2-4 constants, types and round function.
`timescale 1ns / 1ps
package sip24_pkg;

   localparam logic [63:0] SipInitA     = 64'h736f6d6570736575;
   localparam logic [63:0] SipInitB     = 64'h646f72616e646f6d;
   localparam logic [63:0] SipInitC     = 64'h6c7967656e657261;
   localparam logic [63:0] SipInitD     = 64'h7465646279746573;
   localparam logic [7:0]  SipFinalXor  = 8'hff;
   localparam logic [63:0] KeyLowReset  = 64'h0706050403020100;
   localparam logic [63:0] KeyHighReset = 64'h0f0e0d0c0b0a0908;

   // Input item function codes.
   localparam logic [1:0] FuncByte   = 2'd0;
   localparam logic [1:0] FuncLast   = 2'd1;
   localparam logic [1:0] FuncEnd    = 2'd2;
   localparam logic [1:0] FuncIgnore = 2'd3;

   // Configuration register indexes.
   localparam logic CsrKeyLow  = 1'b0;
   localparam logic CsrKeyHigh = 1'b1;

   // Command queue between the byte front end and the round engine.
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [63:0] d;
   } lanes_type;

   // One command for the round engine: optional lane load, optional full
   // word, optional tail word with finalization.
   typedef struct packed {
      logic        start;
      logic        full_vld;
      logic [63:0] full_word;
      logic        fin;
      logic [63:0] tail_word;
   } cmd_type;

   function automatic logic [63:0] rot_left(logic [63:0] v, int unsigned n);
      return (v << n) | (v >> (64 - n));
   endfunction

   function automatic lanes_type sip_round(lanes_type s);
      lanes_type r;
      r = s;
      r.a = r.a + r.b;
      r.b = rot_left(r.b, 13) ^ r.a;
      r.a = rot_left(r.a, 32);
      r.c = r.c + r.d;
      r.d = rot_left(r.d, 16) ^ r.c;
      r.a = r.a + r.d;
      r.d = rot_left(r.d, 21) ^ r.a;
      r.c = r.c + r.b;
      r.b = rot_left(r.b, 17) ^ r.c;
      r.c = rot_left(r.c, 32);
      return r;
   endfunction

endpackage

// ----- src/sip24_req_if.sv -----
// Interface for the message byte channel.
`timescale 1ns / 1ps
interface sip24_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;

   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ----- src/sip24_rsp_if.sv -----
// Interface for the hash result channel.
`timescale 1ns / 1ps
interface sip24_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

// ----- src/siphash_2_4_stream.sv -----
// Top level of the streaming SipHash-2-4 keyed hash engine.
`timescale 1ns / 1ps
// SipHash-2-4 over a byte stream. Each transfer on req_if carries one
// message byte (func 0), the last byte of a message (func 1) or a bare end of
// message (func 2, which also hashes an empty message); func 3 is dropped. The
// front end takes one transfer per cycle whenever its two-entry command queue
// has room, packs bytes little-endian into 64-bit words and hands the round
// engine a command at message start, at every eighth byte and at message end.
// The round engine runs one SipRound per cycle while busy: a command is taken
// in BK_IDLE, a full word runs in BK_FULL, and the tail word and finalization
// in BK_TAIL and BK_FIN. A steady byte stream goes at one byte per cycle, as
// the engine keeps pace. A message end adds BK_TAIL and BK_FIN, with BK_FULL
// first when its last byte completes a word, and the opening byte of a longer
// message is a command of its own, so a run of very short messages fills the
// queue and holds off the input until the engine catches up. The 64-bit hash
// then shows up on rsp_if, where it is held in an output register while the
// front end keeps taking bytes. The keys on csr_write_data (index 0 is k0,
// index 1 is k1) are sampled when the engine picks up the first command of a
// message; write them only while the block is quiet.
module siphash_2_4_stream
   import sip24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sip24_req_if.sink   req_if,
   sip24_rsp_if.source rsp_if,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] key_low_ff, key_low_in;
   logic [63:0] key_high_ff, key_high_in;

   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   // Key registers take a write on any cycle the enable is high.
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrKeyLow:  key_low_in  = csr_write_data;
            CsrKeyHigh: key_high_in = csr_write_data;
            default:    key_low_in  = key_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= KeyLowReset;
         key_high_ff <= KeyHighReset;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
      end
   end

   // Byte gathering and command generation.
   sip24_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Decouples the byte side from the round engine.
   sip24_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_cmd    (front_cmd),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_cmd   (back_cmd),
      .out_ready (back_ready)
   );

   // SipRound engine with the result register.
   sip24_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key_low   (key_low_ff),
      .key_high  (key_high_ff),
      .cmd_valid (back_valid),
      .cmd       (back_cmd),
      .cmd_ready (back_ready),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- src/sip24_front.sv -----
// Front end: accepts message bytes, packs words and issues round commands.
`timescale 1ns / 1ps
module sip24_front
   import sip24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sip24_req_if.sink   req_if,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   logic [55:0] gather_ff, gather_in;
   logic [2:0]  slot_ff, slot_in;
   logic [7:0]  len_ff, len_in;
   logic        open_ff, open_in;

   logic        accept;
   logic        start;
   logic        has_byte;
   logic        full;
   logic        fin;
   logic [55:0] cur_gather;
   logic [2:0]  cur_slot;
   logic [7:0]  cur_len;
   logic [55:0] next_gather;
   logic [2:0]  next_slot;
   logic [7:0]  next_len;

   assign req_if.ready = cmd_ready;
   assign accept = req_if.valid && cmd_ready && (req_if.func != FuncIgnore);

   always_comb begin
      start      = !open_ff;
      cur_gather = start ? 56'd0 : gather_ff;
      cur_slot   = start ? 3'd0 : slot_ff;
      cur_len    = start ? 8'd0 : len_ff;
      has_byte   = (req_if.func == FuncByte) || (req_if.func == FuncLast);
      fin        = (req_if.func == FuncLast) || (req_if.func == FuncEnd);
      full       = has_byte && (cur_slot == 3'd7);

      if (full) begin
         next_gather = 56'd0;
         next_slot   = 3'd0;
      end else if (has_byte) begin
         next_gather = cur_gather | (56'(req_if.data_byte) << {cur_slot, 3'b000});
         next_slot   = cur_slot + 3'd1;
      end else begin
         next_gather = cur_gather;
         next_slot   = cur_slot;
      end
      next_len = cur_len + 8'(has_byte);

      cmd.start     = start;
      cmd.full_vld  = full;
      cmd.full_word = {req_if.data_byte, cur_gather};
      cmd.fin       = fin;
      cmd.tail_word = {next_len, next_gather};
      cmd_valid     = accept && (start || full || fin);

      gather_in = gather_ff;
      slot_in   = slot_ff;
      len_in    = len_ff;
      open_in   = open_ff;
      if (accept) begin
         if (fin) begin
            gather_in = 56'd0;
            slot_in   = 3'd0;
            len_in    = 8'd0;
            open_in   = 1'b0;
         end else begin
            gather_in = next_gather;
            slot_in   = next_slot;
            len_in    = next_len;
            open_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gather_ff <= 56'd0;
         slot_ff   <= 3'd0;
         len_ff    <= 8'd0;
         open_ff   <= 1'b0;
      end else begin
         gather_ff <= gather_in;
         slot_ff   <= slot_in;
         len_ff    <= len_in;
         open_ff   <= open_in;
      end
   end

endmodule

// ----- src/sip24_queue.sv -----
// Short command queue between the front end and the round engine.
`timescale 1ns / 1ps
module sip24_queue
   import sip24_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cmd_type in_cmd,
   output logic    in_ready,
   output logic    out_valid,
   output cmd_type out_cmd,
   input  logic    out_ready
);

   cmd_type               entries_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   function automatic logic [PtrWidth-1:0] ptr_next(logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(QueueDepth - 1)) ? '0 : p + PtrWidth'(1);
   endfunction

   assign in_ready  = (count_ff != CountWidth'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CountWidth'(push) - CountWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/sip24_back.sv -----
// Round engine: runs SipRounds per command and holds the result register.
`timescale 1ns / 1ps
`include "siphash_2_4_stream_macros.svh"
module sip24_back
   import sip24_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] key_low,
   input  logic [63:0] key_high,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_ready,
   sip24_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FULL,
      BK_TAIL,
      BK_FIN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  round_ff, round_in;
   lanes_type   lanes_ff, lanes_in;
   cmd_type     cmd_ff, cmd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] hash_ff, hash_in;

   lanes_type   init;
   lanes_type   pre;
   lanes_type   rnd;
   lanes_type   post;
   logic [63:0] word;
   logic        absorbing;
   logic        pop;

   // A finalizing command waits until the result register is free.
   assign cmd_ready = (phase_ff == BK_IDLE) &&
                      (!cmd.fin || !rsp_valid_ff || rsp_if.ready);
   assign pop = cmd_valid && cmd_ready;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hash_value = hash_ff;

   always_comb begin
      init.a = SipInitA ^ key_low;
      init.b = SipInitB ^ key_high;
      init.c = SipInitC ^ key_low;
      init.d = SipInitD ^ key_high;

      absorbing = (phase_ff == BK_FULL) || (phase_ff == BK_TAIL);
      word      = (phase_ff == BK_FULL) ? cmd_ff.full_word : cmd_ff.tail_word;

      pre = lanes_ff;
      if (absorbing && (round_ff == 2'd0)) begin
         pre.d = lanes_ff.d ^ word;
      end
      rnd  = sip_round(pre);
      post = rnd;
      if (absorbing && (round_ff == 2'd1)) begin
         post.a = rnd.a ^ word;
      end
      if ((phase_ff == BK_TAIL) && (round_ff == 2'd1)) begin
         post.c = rnd.c ^ 64'(SipFinalXor);
      end

      phase_in     = phase_ff;
      round_in     = round_ff;
      lanes_in     = lanes_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      case (phase_ff)
         BK_IDLE: begin
            if (pop) begin
               cmd_in   = cmd;
               round_in = 2'd0;
               if (cmd.start) begin
                  lanes_in = init;
               end
               if (cmd.full_vld) begin
                  phase_in = BK_FULL;
               end else if (cmd.fin) begin
                  phase_in = BK_TAIL;
               end else begin
                  phase_in = BK_IDLE;
               end
            end
         end
         BK_FULL: begin
            lanes_in = post;
            if (round_ff == 2'd1) begin
               round_in = 2'd0;
               phase_in = cmd_ff.fin ? BK_TAIL : BK_IDLE;
            end else begin
               round_in = round_ff + 2'd1;
            end
         end
         BK_TAIL: begin
            lanes_in = post;
            if (round_ff == 2'd1) begin
               round_in = 2'd0;
               phase_in = BK_FIN;
            end else begin
               round_in = round_ff + 2'd1;
            end
         end
         BK_FIN: begin
            lanes_in = post;
            if (round_ff == 2'd3) begin
               round_in     = 2'd0;
               phase_in     = BK_IDLE;
               rsp_valid_in = 1'b1;
               hash_in      = post.a ^ post.b ^ post.c ^ post.d;
            end else begin
               round_in = round_ff + 2'd1;
            end
         end
         default: begin
            phase_in = BK_IDLE;
            round_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      cmd_ff   <= cmd_in;
      hash_ff  <= hash_in;
      if (reset) begin
         phase_ff     <= BK_IDLE;
         round_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Finalization never runs while an older hash still sits in the output.
   `SIP24_ASSERT_NOW(a_fin_output_free, clock, reset, phase_ff == BK_FIN, !rsp_valid_ff)
   // A new hash appears only right after the last finalization round.
   `SIP24_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff),
      $past(phase_ff == BK_FIN && round_ff == 2'd3))
   // The engine takes commands only between them, with the round count cleared.
   `SIP24_ASSERT_NEXT(a_pop_clean, clock, reset, pop, $past(round_ff) == 2'd0)

endmodule
